FILE: design/assert_macros.svh
// Assertion macros used by the checker in scj_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define SCJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SCJ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/scj_pkg.sv
package scj_pkg;

  localparam int COORD_BITS = 12;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int LEN_W      = SQ_W + 1;
  localparam int PROD_W     = LEN_W + 16;
  localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = 16;
  localparam int RES_W      = 9;
  localparam int RADIUS_W   = 8;
  localparam int RSQ_W      = 2 * RADIUS_W;

  localparam logic [15:0] Q16_VERT  = 16'd63560;
  localparam logic [15:0] Q16_HORIZ = 16'd1976;

  localparam logic [1:0] CLS_HORIZONTAL = 2'd0;
  localparam logic [1:0] CLS_VERTICAL   = 2'd1;
  localparam logic [1:0] CLS_OTHER      = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd10;

  localparam int  PADDR_W          = 3;
  localparam logic REG_MATCH_RADIUS = 1'b0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [1:0]            cls_t;

  typedef struct packed {
    coord_t b_y1;
    coord_t b_x1;
    coord_t b_y0;
    coord_t b_x0;
    coord_t a_y1;
    coord_t a_x1;
    coord_t a_y0;
    coord_t a_x0;
  } coord_set_t;

  typedef struct packed {
    logic mid_y_less;
    logic mid_y_greater;
    logic mid_x_less;
    logic mid_x_greater;
    logic joint;
    cls_t type_b;
    cls_t type_a;
  } result_t;

  typedef struct packed {
    logic x_greater;
    logic x_less;
    logic y_greater;
    logic y_less;
  } mid_flags_t;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  function automatic cls_t classify(input sq_t dy2, input logic len_zero,
                                    input prod_t vert_rhs, input prod_t horz_rhs);
    prod_t lhs;
    lhs = prod_t'({dy2, 16'h0000});
    if (len_zero) begin
      return CLS_OTHER;
    end else if (lhs > vert_rhs) begin
      return CLS_VERTICAL;
    end else if (lhs < horz_rhs) begin
      return CLS_HORIZONTAL;
    end
    return CLS_OTHER;
  endfunction

endpackage

FILE: design/scj_pipe.sv
module scj_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scj_pkg::coord_set_t              in_coord,
  input  logic [scj_pkg::RSQ_W-1:0]        radius_sq,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scj_pkg::result_t                 out_res
);
  import scj_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: differences and midpoint compares.
  coord_t     s1_adx, s1_ady, s1_bdx, s1_bdy;
  coord_t     s1_pdx [4];
  coord_t     s1_pdy [4];
  mid_flags_t s1_mid;

  // Stage 2: squares.
  sq_t        s2_adx2, s2_ady2, s2_bdx2, s2_bdy2;
  sq_t        s2_pdx2 [4];
  sq_t        s2_pdy2 [4];
  mid_flags_t s2_mid;

  // Stage 3: squared lengths and the radius test.
  len_t       s3_alen, s3_blen;
  sq_t        s3_ady2, s3_bdy2;
  logic       s3_near;
  mid_flags_t s3_mid;

  // Stage 4: threshold products.
  prod_t      s4_av, s4_ah, s4_bv, s4_bh;
  sq_t        s4_ady2, s4_bdy2;
  logic       s4_azero, s4_bzero;
  logic       s4_near;
  mid_flags_t s4_mid;

  coord_t     px_a [4];
  coord_t     py_a [4];
  coord_t     px_b [4];
  coord_t     py_b [4];
  logic [COORD_BITS:0] amx, amy, bmx, bmy;
  logic [3:0] pair_near;
  cls_t       ta, tb;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Endpoint pairings: A0-B0, A1-B0, A0-B1, A1-B1.
  always_comb begin
    px_a[0] = in_coord.a_x0;  py_a[0] = in_coord.a_y0;
    px_b[0] = in_coord.b_x0;  py_b[0] = in_coord.b_y0;
    px_a[1] = in_coord.a_x1;  py_a[1] = in_coord.a_y1;
    px_b[1] = in_coord.b_x0;  py_b[1] = in_coord.b_y0;
    px_a[2] = in_coord.a_x0;  py_a[2] = in_coord.a_y0;
    px_b[2] = in_coord.b_x1;  py_b[2] = in_coord.b_y1;
    px_a[3] = in_coord.a_x1;  py_a[3] = in_coord.a_y1;
    px_b[3] = in_coord.b_x1;  py_b[3] = in_coord.b_y1;
  end

  assign amx = ({1'b0, in_coord.a_x0} + {1'b0, in_coord.a_x1}) >> 1;
  assign amy = ({1'b0, in_coord.a_y0} + {1'b0, in_coord.a_y1}) >> 1;
  assign bmx = ({1'b0, in_coord.b_x0} + {1'b0, in_coord.b_x1}) >> 1;
  assign bmy = ({1'b0, in_coord.b_y0} + {1'b0, in_coord.b_y1}) >> 1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair_near[i] = (len_t'(s2_pdx2[i]) + len_t'(s2_pdy2[i])) <= len_t'(radius_sq);
    end
  end

  assign ta = classify(s4_ady2, s4_azero, s4_av, s4_ah);
  assign tb = classify(s4_bdy2, s4_bzero, s4_bv, s4_bh);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_adx           <= abs_diff(in_coord.a_x0, in_coord.a_x1);
      s1_ady           <= abs_diff(in_coord.a_y0, in_coord.a_y1);
      s1_bdx           <= abs_diff(in_coord.b_x0, in_coord.b_x1);
      s1_bdy           <= abs_diff(in_coord.b_y0, in_coord.b_y1);
      for (int i = 0; i < 4; i++) begin
        s1_pdx[i] <= abs_diff(px_a[i], px_b[i]);
        s1_pdy[i] <= abs_diff(py_a[i], py_b[i]);
      end
      s1_mid.x_greater <= amx > bmx;
      s1_mid.x_less    <= amx < bmx;
      s1_mid.y_greater <= amy > bmy;
      s1_mid.y_less    <= amy < bmy;
    end
    if (rdy2) begin
      s2_adx2 <= sq_t'(s1_adx) * sq_t'(s1_adx);
      s2_ady2 <= sq_t'(s1_ady) * sq_t'(s1_ady);
      s2_bdx2 <= sq_t'(s1_bdx) * sq_t'(s1_bdx);
      s2_bdy2 <= sq_t'(s1_bdy) * sq_t'(s1_bdy);
      for (int i = 0; i < 4; i++) begin
        s2_pdx2[i] <= sq_t'(s1_pdx[i]) * sq_t'(s1_pdx[i]);
        s2_pdy2[i] <= sq_t'(s1_pdy[i]) * sq_t'(s1_pdy[i]);
      end
      s2_mid <= s1_mid;
    end
    if (rdy3) begin
      s3_alen <= len_t'(s2_adx2) + len_t'(s2_ady2);
      s3_blen <= len_t'(s2_bdx2) + len_t'(s2_bdy2);
      s3_ady2 <= s2_ady2;
      s3_bdy2 <= s2_bdy2;
      s3_near <= |pair_near;
      s3_mid  <= s2_mid;
    end
    if (rdy4) begin
      s4_av    <= prod_t'(s3_alen) * prod_t'(Q16_VERT);
      s4_ah    <= prod_t'(s3_alen) * prod_t'(Q16_HORIZ);
      s4_bv    <= prod_t'(s3_blen) * prod_t'(Q16_VERT);
      s4_bh    <= prod_t'(s3_blen) * prod_t'(Q16_HORIZ);
      s4_ady2  <= s3_ady2;
      s4_bdy2  <= s3_bdy2;
      s4_azero <= s3_alen == '0;
      s4_bzero <= s3_blen == '0;
      s4_near  <= s3_near;
      s4_mid   <= s3_mid;
    end
    if (rdy5) begin
      out_res.type_a        <= ta;
      out_res.type_b        <= tb;
      out_res.joint         <= (ta != tb) && s4_near;
      out_res.mid_x_greater <= s4_mid.x_greater;
      out_res.mid_x_less    <= s4_mid.x_less;
      out_res.mid_y_greater <= s4_mid.y_greater;
      out_res.mid_y_less    <= s4_mid.y_less;
    end
  end

  assign out_valid = v5;

endmodule

FILE: design/segment_classify_and_joint_top.sv
// Segment pair classifier and joint detector.
// The slave stream takes one word per pair of segments: eight endpoint
// coordinates, and the master stream returns one word per input word with
// the two segment classes, the joint flag and the midpoint compare flags.
// A word is moved at a rising clock edge where tvalid and tready are both high.
// Five register stages lie between the two streams: differences, squares,
// sums with the radius test, threshold products, and the output register.
// Throughput is one word per cycle while m_tready is high; the two multiplier
// stages set the depth. When the receiver holds m_tready low, the stages fill
// up behind the output register and s_tready falls only once no empty stage
// is left.
// Reset empties the pipeline and sets match_radius to 10. The radius register
// sits at byte address 0 of the APB port; reads return its value. It must be
// written only while the stream is idle; the block itself does not enforce this.
module segment_classify_and_joint_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1, 12 bits each.
  input  logic [scj_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // type_a[1:0], type_b[3:2], joint, mid_x_greater, mid_x_less,
  // mid_y_greater, mid_y_less, then seven zero bits.
  output logic [scj_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scj_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import scj_pkg::*;

  logic [RADIUS_W-1:0] match_radius;
  logic [RSQ_W-1:0]    radius_sq;
  coord_set_t          coords;
  result_t             res;

  assign pready = 1'b1;
  assign coords = coord_set_t'(s_tdata[8*COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_MATCH_RADIUS) begin
      match_radius <= pwdata[RADIUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    radius_sq <= RSQ_W'(match_radius) * RSQ_W'(match_radius);
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MATCH_RADIUS) begin
      prdata = 32'(match_radius);
    end
  end

  scj_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_coord  (coords),
    .radius_sq (radius_sq),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = OUT_W'(res);

endmodule

FILE: design/scj_checker.sv
`include "assert_macros.svh"

module scj_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [scj_pkg::OUT_W-1:0] m_tdata
);
  import scj_pkg::*;

  `SCJ_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "output valid right after reset")
  `SCJ_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "stalled word dropped")
  `SCJ_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled word changed")
  `SCJ_ASSERT(a_joint_needs_diff, m_tvalid && m_tdata[1:0] == m_tdata[3:2] |-> !m_tdata[4], "joint with equal classes")
  `SCJ_ASSERT(a_mid_exclusive, m_tvalid |-> !(m_tdata[5] && m_tdata[6]) && !(m_tdata[7] && m_tdata[8]), "midpoint both greater and less")

endmodule

bind segment_classify_and_joint_top scj_checker u_scj_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import scj_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LATENCY = 5;
  localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int MAX_REPORTS = 10;
  localparam int RADIUS_PHASES = 7;
  localparam int WORDS_PER_PHASE = 90;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam logic [PADDR_W-1:0] RADIUS_ADDR = PADDR_W'(4 * REG_MATCH_RADIUS);
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4 * (REG_MATCH_RADIUS + 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  coord_set_t pending_words[$];
  result_t expected_outcomes[$];
  coord_set_t offered_word;
  result_t want_word;
  result_t seen_word;
  logic [RADIUS_W-1:0] radius_setting = RADIUS_RESET;
  bit gaps_enabled = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int joints_seen = 0;
  int settings_used = 1;
  int class_count[3] = '{0, 0, 0};

  segment_classify_and_joint_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint unsigned span_sq(input coord_t xa, input coord_t ya,
                                              input coord_t xb, input coord_t yb);
    longint unsigned run;
    longint unsigned rise;
    run = (xa >= xb) ? 64'(xa) - 64'(xb) : 64'(xb) - 64'(xa);
    rise = (ya >= yb) ? 64'(ya) - 64'(yb) : 64'(yb) - 64'(ya);
    return run * run + rise * rise;
  endfunction

  function automatic cls_t segment_class(input coord_t x0, input coord_t y0,
                                         input coord_t x1, input coord_t y1);
    longint unsigned rise;
    longint unsigned len2;
    longint unsigned scaled_rise;
    rise = (y0 >= y1) ? 64'(y0) - 64'(y1) : 64'(y1) - 64'(y0);
    len2 = span_sq(x0, y0, x1, y1);
    scaled_rise = (rise * rise) << 16;
    if (len2 == 0) begin
      return CLS_OTHER;
    end else if (scaled_rise > 64'(Q16_VERT) * len2) begin
      return CLS_VERTICAL;
    end else if (scaled_rise < 64'(Q16_HORIZ) * len2) begin
      return CLS_HORIZONTAL;
    end
    return CLS_OTHER;
  endfunction

  function automatic result_t pair_outcome(input coord_set_t w,
                                           input logic [RADIUS_W-1:0] radius);
    result_t r;
    longint unsigned reach2;
    int amx;
    int amy;
    int bmx;
    int bmy;
    r.type_a = segment_class(w.a_x0, w.a_y0, w.a_x1, w.a_y1);
    r.type_b = segment_class(w.b_x0, w.b_y0, w.b_x1, w.b_y1);
    reach2 = 64'(radius) * 64'(radius);
    r.joint = (r.type_a != r.type_b) &&
              (span_sq(w.a_x0, w.a_y0, w.b_x0, w.b_y0) <= reach2 ||
               span_sq(w.a_x1, w.a_y1, w.b_x0, w.b_y0) <= reach2 ||
               span_sq(w.a_x0, w.a_y0, w.b_x1, w.b_y1) <= reach2 ||
               span_sq(w.a_x1, w.a_y1, w.b_x1, w.b_y1) <= reach2);
    amx = (int'(w.a_x0) + int'(w.a_x1)) >> 1;
    amy = (int'(w.a_y0) + int'(w.a_y1)) >> 1;
    bmx = (int'(w.b_x0) + int'(w.b_x1)) >> 1;
    bmy = (int'(w.b_y0) + int'(w.b_y1)) >> 1;
    r.mid_x_greater = amx > bmx;
    r.mid_x_less = amx < bmx;
    r.mid_y_greater = amy > bmy;
    r.mid_y_less = amy < bmy;
    return r;
  endfunction

  function automatic coord_t nudge(input coord_t c, input int delta);
    int v;
    v = int'(c) + delta;
    if (v < 0) begin
      v = 0;
    end else if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    return coord_t'(v);
  endfunction

  function automatic void grow_segment(input coord_t sx, input coord_t sy,
                                       output coord_t ex, output coord_t ey);
    int run;
    int rise;
    int base;
    int swap;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        run = $urandom_range(8, 1500);
        rise = $urandom_range(0, run / 6);
      end
      3, 4, 5: begin
        rise = $urandom_range(8, 1500);
        run = $urandom_range(0, rise / 6);
      end
      6, 7: begin
        run = $urandom_range(1, 1500);
        rise = $urandom_range(1, 1500);
      end
      8: begin
        // The slope sits within a few units of either angle threshold.
        base = $urandom_range(1, 700);
        run = base;
        rise = base * 56715 / 10000 + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) begin
          swap = run;
          run = rise;
          rise = swap;
        end
      end
      default: begin
        run = $urandom_range(0, 2);
        rise = $urandom_range(0, 2);
      end
    endcase
    ex = nudge(sx, $urandom_range(0, 1) ? run : -run);
    ey = nudge(sy, $urandom_range(0, 1) ? rise : -rise);
  endfunction

  function automatic coord_set_t random_pair(input logic [RADIUS_W-1:0] radius);
    coord_set_t w;
    coord_t ox;
    coord_t oy;
    coord_t fx;
    coord_t fy;
    int reach;
    int style;
    reach = int'(radius) + 3;
    style = $urandom_range(0, 19);
    w = '0;
    w.a_x0 = coord_t'($urandom_range(0, COORD_MAX));
    w.a_y0 = coord_t'($urandom_range(0, COORD_MAX));
    grow_segment(w.a_x0, w.a_y0, w.a_x1, w.a_y1);
    if (style < 3) begin
      w = coord_set_t'({$urandom, $urandom, $urandom});
    end else if (style == 3) begin
      w.b_x0 = w.a_x1;
      w.b_y0 = w.a_y1;
      w.b_x1 = w.a_x0;
      w.b_y1 = w.a_y0;
    end else begin
      // B starts near one endpoint of A so that joints actually occur.
      if ($urandom_range(0, 1)) begin
        ox = w.a_x0;
        oy = w.a_y0;
      end else begin
        ox = w.a_x1;
        oy = w.a_y1;
      end
      if ($urandom_range(0, 3) != 0) begin
        ox = nudge(ox, int'($urandom_range(0, 2 * reach)) - reach);
        oy = nudge(oy, int'($urandom_range(0, 2 * reach)) - reach);
      end
      grow_segment(ox, oy, fx, fy);
      if ($urandom_range(0, 1)) begin
        w.b_x0 = ox;
        w.b_y0 = oy;
        w.b_x1 = fx;
        w.b_y1 = fy;
      end else begin
        w.b_x0 = fx;
        w.b_y0 = fy;
        w.b_x1 = ox;
        w.b_y1 = oy;
      end
    end
    return w;
  endfunction

  function automatic coord_set_t pair_of(input int ax0, input int ay0, input int ax1,
                                         input int ay1, input int bx0, input int by0,
                                         input int bx1, input int by1);
    coord_set_t w;
    w.a_x0 = coord_t'(ax0);
    w.a_y0 = coord_t'(ay0);
    w.a_x1 = coord_t'(ax1);
    w.a_y1 = coord_t'(ay1);
    w.b_x0 = coord_t'(bx0);
    w.b_y0 = coord_t'(by0);
    w.b_x1 = coord_t'(bx1);
    w.b_y1 = coord_t'(by1);
    return w;
  endfunction

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == RADIUS_ADDR) begin
      radius_setting = data[RADIUS_W-1:0];
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(radius_setting)) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Radius readback: expected %0d, got %h", radius_setting, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_outcomes.push_back(pair_outcome(offered_word, radius_setting));
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0 && gaps_enabled &&
                     $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          offered_word = pending_words.pop_front();
          s_tdata <= offered_word;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_word = m_tdata[RES_W-1:0];
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Result word %h arrived with nothing pending", m_tdata);
          end
        end else begin
          want_word = expected_outcomes.pop_front();
          results_checked++;
          class_count[want_word.type_a]++;
          class_count[want_word.type_b]++;
          if (want_word.joint) begin
            joints_seen++;
          end
          if (seen_word !== want_word || m_tdata[OUT_W-1:RES_W] !== '0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display({"Result %0d (expected/actual): type_a %0d/%0d type_b %0d/%0d ",
                        "joint %b/%b x> %b/%b x< %b/%b y> %b/%b y< %b/%b pad %h"},
                       results_checked, want_word.type_a, seen_word.type_a,
                       want_word.type_b, seen_word.type_b, want_word.joint,
                       seen_word.joint, want_word.mid_x_greater, seen_word.mid_x_greater,
                       want_word.mid_x_less, seen_word.mid_x_less,
                       want_word.mid_y_greater, seen_word.mid_y_greater,
                       want_word.mid_y_less, seen_word.mid_y_less,
                       m_tdata[OUT_W-1:RES_W]);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No word moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [RADIUS_W-1:0] target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_write(UNMAPPED_ADDR, $urandom);
    apb_read_check(RADIUS_ADDR);

    pending_words.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(pair_of(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    pending_words.push_back(pair_of(0, 0, 4095, 0, 4095, 0, 4095, 4095));
    pending_words.push_back(pair_of(0, 4095, 4095, 4095, 0, 0, 0, 4095));
    pending_words.push_back(pair_of(100, 100, 300, 110, 306, 118, 310, 400));
    pending_words.push_back(pair_of(100, 100, 300, 110, 307, 118, 310, 400));
    pending_words.push_back(pair_of(100, 100, 300, 110, 300, 110, 900, 120));
    pending_words.push_back(pair_of(700, 700, 700, 700, 700, 700, 705, 1200));
    pending_words.push_back(pair_of(2000, 2000, 2500, 2500, 2003, 2004, 2600, 2010));
    pending_words.push_back(pair_of(1000, 500, 1500, 3335, 1000, 500, 1500, 3336));
    pending_words.push_back(pair_of(500, 1000, 3335, 1500, 500, 1000, 3336, 1500));
    pending_words.push_back(pair_of(0, 10, 3, 13, 1, 11, 2, 12));
    pending_words.push_back(pair_of(4095, 4095, 4094, 4094, 0, 0, 1, 1));
    pending_words.push_back(pair_of('hAAA, 'h555, 'h555, 'hAAA, 'h555, 'hAAA, 'hAAA, 'h555));
    pending_words.push_back(pair_of(2000, 0, 2000, 4095, 2000, 0, 2000, 1));
    pending_words.push_back(pair_of(5, 5, 6, 5, 6, 5, 6, 6));
    pending_words.push_back(pair_of(3000, 3000, 3100, 3000, 3200, 4000, 3106, 3008));
    pending_words.push_back(pair_of(50, 60, 1000, 60, 44, 52, 44, 900));
    pending_words.push_back(pair_of(0, 0, 4095, 4095, 4095, 4095, 0, 4095));
    pending_words.push_back(pair_of(4095, 0, 0, 4095, 4095, 1, 4095, 4095));

    for (int phase = 0; phase < RADIUS_PHASES; phase++) begin
      wait_for_idle();
      if (phase == 0) begin
        target = '0;
      end else if (phase == 1) begin
        target = '1;
      end else if (phase == 2) begin
        target = RADIUS_W'(1);
      end else begin
        target = RADIUS_W'($urandom_range(2, 254));
      end
      apb_write(RADIUS_ADDR, {24'($urandom), target});
      settings_used++;
      if (phase == 3) begin
        apb_write(UNMAPPED_ADDR, $urandom);
      end
      apb_read_check(RADIUS_ADDR);
      if (phase == RADIUS_PHASES - 1) begin
        gaps_enabled = 1'b0;
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pending_words.push_back(random_pair(target));
      end
      if (phase == 1) begin
        holds_asked++;
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d segment pairs under %0d radius settings, including 0, 255 and a long",
             words_sent, settings_used);
    $display("output stall; %0d results compared, %0d joints, classes H/V/O %0d/%0d/%0d.",
             results_checked, joints_seen, class_count[CLS_HORIZONTAL],
             class_count[CLS_VERTICAL], class_count[CLS_OTHER]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
